// File: rtl/lurt_pkg.sv
// ----------------------------------------------------------------------------
// lurt_pkg: shared types and constants of the longest unique run tracker
// Field widths of the input and result words that do not vary with the
// module parameters.
// ----------------------------------------------------------------------------
package lurt_pkg;

	// Width of one character code and of the reported lengths.
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 17;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [LEN_W-1:0]  len_t;

endpackage

// File: rtl/lurt_ram.sv
// ----------------------------------------------------------------------------
// lurt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// its value while no read is requested.
// ----------------------------------------------------------------------------
module lurt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/longest_unique_run_tracker.sv
// ----------------------------------------------------------------------------
// longest_unique_run_tracker: longest run of bytes without a repeated value
// An accepted word moves from stage 1 to the stage-2 output register, which
// offers its result word. Throughput: one word per cycle while the result
// channel does not stall; the position table RAM is read once per word and,
// unless it is dropped, written once, with a bypass for back-to-back same codes.
// Reset: all control state, valid bits and counters clear at once; the RAM
// contents are not cleared (valid bits mask them), so there is no sweep.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker #(
	parameter int MAX_LEN  = 65536,
	parameter int ALPHABET = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	// Input character channel.
	input  logic            char_valid,
	output logic            char_stall,
	input  lurt_pkg::char_t char_code,
	input  logic            string_end,
	// Result channel.
	output logic            result_valid,
	input  logic            result_stall,
	output lurt_pkg::len_t  window_length,
	output lurt_pkg::len_t  best_length,
	output logic            final_result,
	output logic            overflow
);

	// AW indexes the per-code table. PW holds a stored position, which is
	// always below MAX_LEN. CW holds the position counter, the window start
	// and lengths, which may reach MAX_LEN itself.
	localparam int AW     = $clog2(ALPHABET);
	localparam int PW     = $clog2(MAX_LEN);
	localparam int CW     = $clog2(MAX_LEN + 1);
	localparam int NCODES = 2 ** lurt_pkg::CHAR_W;
	localparam logic [CW-1:0] MAX_POS = CW'(MAX_LEN);
	localparam logic [CW-1:0] ONE     = CW'(1);

	// ------------------------------------------------------------------
	// Code folding. A code at or beyond the alphabet size wraps modulo
	// the alphabet size. The table is built from constants, so it is plain
	// logic indexed by the incoming byte.
	// ------------------------------------------------------------------
	logic [AW-1:0] fold_lut [NCODES];
	logic [AW-1:0] code_in;

	always_comb begin
		for (int i = 0; i < NCODES; i++) begin
			fold_lut[i] = AW'(i % ALPHABET);
		end
	end

	assign code_in = fold_lut[char_code];

	// ------------------------------------------------------------------
	// Handshake. Stage 1 holds the word whose table read is in flight and
	// does the read-modify-write. Stage 2 is the output register. Each
	// stage can take a new word in the same cycle its current one leaves.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2;
	logic s2_free, s1_fire, accept;

	assign s2_free      = !valid_s2 || !result_stall;
	assign s1_fire      = valid_s1 && s2_free;
	assign char_stall   = valid_s1 && !s2_free;
	assign accept       = char_valid && !char_stall;
	assign result_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1 payload.
	logic [AW-1:0] code_s1;
	logic          last_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= code_in;
			last_s1 <= string_end;
		end
	end

	// ------------------------------------------------------------------
	// Last-seen position table. The read is issued as the word is accepted,
	// so its data is ready when the word sits in stage 1. The write of the
	// word ahead lands at the same edge as that read, so the read may miss
	// it; the bypass register keeps the most recent write and overrides
	// the RAM data whenever the codes match.
	// ------------------------------------------------------------------
	logic          ram_we;
	logic [PW-1:0] ram_wdata;
	logic [PW-1:0] ram_rdata;

	lurt_ram #(
		.WIDTH (PW),
		.DEPTH (ALPHABET)
	) u_pos_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (code_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (code_in),
		.rdata (ram_rdata)
	);

	logic                byp_vld_q;
	logic [AW-1:0]       byp_code_q;
	logic [PW-1:0]       byp_pos_q;
	logic [ALPHABET-1:0] seen_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       ws_q;
	logic                ovf_q;

	logic [PW-1:0] prev_pos;
	logic          hit;
	logic          sat;
	logic [CW-1:0] after;
	logic [CW-1:0] ws_next;
	logic [CW-1:0] win_s1;

	always_comb begin
		prev_pos = (byp_vld_q && (byp_code_q == code_s1)) ? byp_pos_q : ram_rdata;
		hit      = seen_q[code_s1];
		// Once MAX_LEN bytes are in, further bytes of the string are dropped.
		sat      = (pos_q >= MAX_POS);
		after    = CW'(prev_pos) + ONE;
		ws_next  = (hit && (after > ws_q)) ? after : ws_q;
		// A dropped byte reports the window of the last byte that was taken.
		win_s1   = sat ? (pos_q - ws_q) : (pos_q - ws_next + ONE);
	end

	assign ram_we    = s1_fire && !sat;
	assign ram_wdata = PW'(pos_q);

	// Per-string state. The final byte of a string clears it as it leaves
	// stage 1, so the first byte of the next string sees a fresh table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			pos_q     <= '0;
			ws_q      <= '0;
			ovf_q     <= 1'b0;
			byp_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				byp_vld_q <= 1'b1;
			end
			if (s1_fire) begin
				if (last_s1) begin
					seen_q <= '0;
					pos_q  <= '0;
					ws_q   <= '0;
					ovf_q  <= 1'b0;
				end else if (sat) begin
					ovf_q <= 1'b1;
				end else begin
					seen_q[code_s1] <= 1'b1;
					ws_q            <= ws_next;
					pos_q           <= pos_q + ONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			byp_code_q <= code_s1;
			byp_pos_q  <= ram_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: output register. The best length is folded in here, so the
	// stage-1 loop carries only the window start. best_q holds the best of
	// all words of the string that have already left stage 2.
	// ------------------------------------------------------------------
	logic [CW-1:0] win_s2;
	logic          last_s2;
	logic          ovf_s2;
	logic [CW-1:0] best_q;
	logic [CW-1:0] best_cur;

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			win_s2  <= win_s1;
			last_s2 <= last_s1;
			ovf_s2  <= ovf_q || sat;
		end
	end

	assign best_cur = (win_s2 > best_q) ? win_s2 : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (valid_s2 && !result_stall) begin
			best_q <= last_s2 ? '0 : best_cur;
		end
	end

	assign window_length = lurt_pkg::LEN_W'(win_s2);
	assign best_length   = lurt_pkg::LEN_W'(best_cur);
	assign final_result  = last_s2;
	assign overflow      = ovf_s2;

endmodule

// File: rtl/lurt_checker.sv
// ----------------------------------------------------------------------------
// lurt_checker: port-level checks on the result channel
// Watches the result words of the tracker and checks the handshake and the
// range of the reported lengths.
// ----------------------------------------------------------------------------
module lurt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           result_valid,
	input logic           result_stall,
	input lurt_pkg::len_t window_length,
	input lurt_pkg::len_t best_length,
	input logic           final_result,
	input logic           overflow
);

	// A stalled word stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word withdrawn while stalled");

	// A stalled word does not change.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(window_length) && $stable(best_length)
			&& $stable(final_result) && $stable(overflow))
		else $error("result word changed while stalled");

	// A repeat-free run holds at least one byte and never more than the
	// number of distinct byte values.
	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (window_length != '0) && (window_length <= 17'd256))
		else $error("window length out of range");

	// The best length covers the current window.
	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (window_length <= best_length) && (best_length <= 17'd256))
		else $error("best length below current window");

endmodule

bind longest_unique_run_tracker lurt_checker u_lurt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.window_length (window_length),
	.best_length   (best_length),
	.final_result  (final_result),
	.overflow      (overflow)
);

// File: verif/lurt_run_checker.sv
// ----------------------------------------------------------------------------
// lurt_run_checker: result predictor and scoreboard for the run tracker
// Watches both channels of the longest unique run tracker, works out the
// result word of every accepted character word and compares each accepted
// result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lurt_run_checker #(
	parameter int MAX_LEN  = 65536,
	parameter int ALPHABET = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	input  logic            char_stall,
	input  lurt_pkg::char_t char_code,
	input  logic            string_end,
	input  logic            result_valid,
	input  logic            result_stall,
	input  lurt_pkg::len_t  window_length,
	input  lurt_pkg::len_t  best_length,
	input  logic            final_result,
	input  logic            overflow,
	output int              mismatch_count,
	output int              reports_in_flight
);

	typedef struct packed {
		lurt_pkg::len_t window_length;
		lurt_pkg::len_t best_length;
		logic           final_result;
		logic           overflow;
	} run_report_t;

	run_report_t expected_reports[$];

	// Per-string tracking state, kept wider than the block so saturation is visible.
	int unsigned last_pos [ALPHABET];
	bit          code_seen[ALPHABET];
	int unsigned next_pos;
	int unsigned run_start;
	int unsigned best_run;
	bit          saturated;

	function automatic void clear_string_state();
		foreach (code_seen[i])
			code_seen[i] = 1'b0;
		next_pos  = 0;
		run_start = 0;
		best_run  = 0;
		saturated = 1'b0;
	endfunction

	function automatic run_report_t track_char(lurt_pkg::char_t code, logic is_end);
		run_report_t rep;
		int unsigned idx;
		int unsigned run_len;
		idx = code % ALPHABET;
		if (next_pos >= MAX_LEN) begin
			// The string is full: the character is dropped and nothing moves.
			saturated = 1'b1;
			run_len   = next_pos - run_start;
		end else begin
			if (code_seen[idx] && last_pos[idx] + 1 > run_start)
				run_start = last_pos[idx] + 1;
			last_pos[idx]  = next_pos;
			code_seen[idx] = 1'b1;
			run_len        = next_pos - run_start + 1;
			if (run_len > best_run)
				best_run = run_len;
			next_pos++;
		end
		rep.window_length = lurt_pkg::len_t'(run_len);
		rep.best_length   = lurt_pkg::len_t'(best_run);
		rep.final_result  = is_end;
		rep.overflow      = saturated;
		if (is_end)
			clear_string_state();
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		run_report_t got;
		run_report_t want;
		run_report_t pred;
		if (!arst_n) begin
			expected_reports.delete();
			clear_string_state();
			mismatch_count    <= 0;
			reports_in_flight <= 0;
		end else begin
			if (char_valid && !char_stall) begin
				pred = track_char(char_code, string_end);
				expected_reports.insert(expected_reports.size(), pred);
			end
			if (result_valid && !result_stall) begin
				got = '{window_length, best_length, final_result, overflow};
				if (expected_reports.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("%0t: result word with no prediction waiting", $time);
						$display("  got window=%0d best=%0d final=%0b overflow=%0b",
							got.window_length, got.best_length, got.final_result,
							got.overflow);
					end
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected window=%0d best=%0d final=%0b overflow=%0b",
								want.window_length, want.best_length,
								want.final_result, want.overflow);
							$display("  got      window=%0d best=%0d final=%0b overflow=%0b",
								got.window_length, got.best_length,
								got.final_result, got.overflow);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			reports_in_flight <= expected_reports.size();
		end
	end

endmodule

// File: verif/tb_longest_unique_run_tracker.sv
// ----------------------------------------------------------------------------
// tb_longest_unique_run_tracker: stimulus and verdict for the run tracker
// Feeds directed strings and about two thousand random characters through
// the block under several idle and stall mixes; a separate checker predicts
// and compares results.
// ----------------------------------------------------------------------------
module tb_longest_unique_run_tracker;

	localparam int MAX_LEN     = 65536;
	localparam int ALPHABET    = 256;
	// A safety net that ends the whole run if it hangs.
	localparam int CYCLE_LIMIT = 100000;
	// Length of the receiver hold-off; long enough to fill every pipeline stage.
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_CHARS = 500;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            char_valid;
	logic            char_stall;
	lurt_pkg::char_t char_code;
	logic            string_end;
	logic            result_valid;
	logic            result_stall;
	lurt_pkg::len_t  window_length;
	lurt_pkg::len_t  best_length;
	logic            final_result;
	logic            overflow;

	int mismatch_count;
	int reports_in_flight;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int  idle_pct;
	int  stall_pct;
	// Set by the stimulus process to ask the receiver for one long hold-off.
	bit  hold_results;
	int  chars_sent;
	int  cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longest_unique_run_tracker #(
		.MAX_LEN  (MAX_LEN),
		.ALPHABET (ALPHABET)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.string_end    (string_end),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.window_length (window_length),
		.best_length   (best_length),
		.final_result  (final_result),
		.overflow      (overflow)
	);

	lurt_run_checker #(
		.MAX_LEN  (MAX_LEN),
		.ALPHABET (ALPHABET)
	) u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.char_valid        (char_valid),
		.char_stall        (char_stall),
		.char_code         (char_code),
		.string_end        (string_end),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.window_length     (window_length),
		.best_length       (best_length),
		.final_result      (final_result),
		.overflow          (overflow),
		.mismatch_count    (mismatch_count),
		.reports_in_flight (reports_in_flight)
	);

	// The receiver decides its stall at every falling edge. When a long
	// hold-off is requested it keeps stall high through the hold-off,
	// counting it here, while the sender keeps offering words so that the
	// block backs up and eventually stalls its input.
	initial begin : result_receiver
		int hold_count;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_stall <= 1'b1;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(negedge clk);
					hold_count++;
				end
				hold_results = 1'b0;
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run as a failure.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offers one character word and returns at the edge that accepts it.
	// New values go out at the falling edge; the idle gap in front of the
	// word is drawn cycle by cycle, so gaps land on every pipeline phase.
	task automatic send_char(input lurt_pkg::char_t code, input logic is_end);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			char_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		char_valid <= 1'b1;
		char_code  <= code;
		string_end <= is_end;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_string(input lurt_pkg::char_t codes[$]);
		foreach (codes[i])
			send_char(codes[i], i == codes.size() - 1);
	endtask

	// Drops valid and waits until every predicted result word has come back.
	// The falling edge first lets the checker count the last accepted word.
	task automatic drain_results();
		@(negedge clk);
		char_valid <= 1'b0;
		wait (reports_in_flight == 0);
	endtask

	// One random string. Most strings draw from a narrow span of codes so
	// repeats are frequent and the window start moves often; some draw from
	// the whole byte range; a few are long runs of distinct codes that push
	// the window to the full alphabet before repeats begin.
	task automatic send_random_string();
		lurt_pkg::char_t codes[$];
		int              mode;
		int              len;
		int              span;
		lurt_pkg::char_t base;
		lurt_pkg::char_t code;
		mode = $urandom_range(99);
		base = lurt_pkg::char_t'($urandom_range(255));
		if (mode < 4) begin
			len = $urandom_range(ALPHABET + 40, ALPHABET);
			for (int i = 0; i < len; i++) begin
				if (i < ALPHABET)
					code = lurt_pkg::char_t'(base + i);
				else
					code = lurt_pkg::char_t'($urandom_range(255));
				codes.insert(codes.size(), code);
			end
		end else if (mode < 55) begin
			len  = $urandom_range(40, 1);
			span = $urandom_range(15, 1);
			for (int i = 0; i < len; i++) begin
				code = lurt_pkg::char_t'(base + $urandom_range(span));
				codes.insert(codes.size(), code);
			end
		end else begin
			len = $urandom_range(40, 1);
			for (int i = 0; i < len; i++) begin
				code = lurt_pkg::char_t'($urandom_range(255));
				codes.insert(codes.size(), code);
			end
		end
		send_string(codes);
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_code    = '0;
		string_end   = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_results = 1'b0;
		chars_sent   = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed strings. Single-character strings at both code extremes,
		// the same code back to back (exercises the table bypass), alternating
		// bit patterns, a repeat whose earlier position already lies before
		// the window start, and a repeat of the first code at the far end.
		send_string('{8'h00});
		send_string('{8'hFF});
		send_string('{8'h41, 8'h41, 8'h41});
		send_string('{8'h55, 8'hAA, 8'h55});
		send_string('{8'h01, 8'h02, 8'h02, 8'h01});
		send_string('{8'h10, 8'h20, 8'h30, 8'h40, 8'h10});
		send_string('{8'h80, 8'h7F, 8'h80, 8'h7F});
		drain_results();

		// Random phases: no idling, sender idle, receiver stalling, both.
		// The first phase opens with the long receiver hold-off; every phase
		// ends with the sender pausing until all results are home.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct     = 0;
					stall_pct    = 0;
					hold_results = 1'b1;
				end
				1: begin
					idle_pct  = 46;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 46;
				end
				default: begin
					idle_pct  = 16;
					stall_pct = 16;
				end
			endcase
			chars_sent = 0;
			while (chars_sent < PHASE_CHARS)
				send_random_string();
			drain_results();
		end

		// Let any stray result word show up before the verdict.
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && reports_in_flight == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
